FILE: hw/rtl/weighted_3x3_smooth_top_defines.svh
// Assertion macros for the weighted 3x3 smoothing block.
// Used by the modules of hw/rtl that carry concurrent checks; needs a clk and rst in scope.
`ifndef WEIGHTED_3X3_SMOOTH_TOP_DEFINES_SVH
`define WEIGHTED_3X3_SMOOTH_TOP_DEFINES_SVH
`ifndef SYNTH
// Check that holds at every edge outside reset.
`define SMOOTH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that is evaluated during reset as well.
`define SMOOTH_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SMOOTH_ASSERT(name, prop, msg)
`define SMOOTH_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

FILE: hw/rtl/w3s_pkg.sv
// Shared types, constants and helper functions of the weighted 3x3 smoothing block.
// No dependencies; every module of hw/rtl imports it.
`default_nettype none
package w3s_pkg;

  localparam int CFG_W        = 11;
  localparam int MAX_SIZE_DEF = 1024;
  localparam int SIZE_RESET   = 64;
  localparam int PIX_W        = 8;
  localparam int PX_W         = 3 * PIX_W;
  localparam int SUM_W        = 12;
  localparam int DIV_W        = 4;
  localparam int RECIP_W      = 16;
  localparam int RECIP_SHIFT  = 16;
  localparam int FIFO_DEPTH   = 8;

  // Input item kinds carried in tuser.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // One RGB pixel, red in the lowest bits.
  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  // One window column: two rows back, one row back, current row.
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } col_t;

  // Per-row weight of a column cell (0, 1 or 2).
  typedef struct packed {
    logic [1:0] top;
    logic [1:0] mid;
    logic [1:0] bot;
  } wt_t;

  // Per-channel weighted sums.
  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } csum_t;

  // Which neighbors of the output pixel lie inside the image.
  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
    logic single;
  } edge_t;

  // One result as it waits in the output queue.
  typedef struct packed {
    logic   last;
    pixel_t px;
  } result_t;

  // Weight one channel value by 0, 1 or 2.
  function automatic logic [SUM_W-1:0] scale(input logic [PIX_W-1:0] v, input logic [1:0] w);
    logic [SUM_W-1:0] e;
    logic [SUM_W-1:0] r;
    e = SUM_W'(v);
    case (w)
      2'd1:    r = e;
      2'd2:    r = e << 1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Number of counted pixels, the center counting twice.
  function automatic logic [DIV_W-1:0] divisor(input edge_t e);
    logic [DIV_W-1:0] span;
    logic [DIV_W-1:0] n;
    span = DIV_W'(1) + DIV_W'(e.left) + DIV_W'(e.right);
    n    = DIV_W'(2) + DIV_W'(e.left) + DIV_W'(e.right);
    if (e.top) n = n + span;
    if (e.bot) n = n + span;
    return n;
  endfunction

  // Scaled reciprocal: (sum * recip) >> RECIP_SHIFT is exact for sums up to 2550.
  function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd2:    r = 16'd32768;
      4'd5:    r = 16'd13108;
      4'd7:    r = 16'd9363;
      4'd10:   r = 16'd6554;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/w3s_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on w3s_pkg for default widths only.
`default_nettype none
module w3s_ram
  import w3s_pkg::*;
#(
  parameter int WIDTH = PX_W,
  parameter int DEPTH = MAX_SIZE_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; a read of the address being written returns the old word.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/w3s_cell.sv
// One column cell of the 3x3 window: holds a column and forms its weighted sums.
// Depends on w3s_pkg.
`default_nettype none
module w3s_cell
  import w3s_pkg::*;
(
  input  wire logic clk,
  input  wire logic shift,
  input  wire col_t col_in,
  input  wire wt_t  wt,
  output col_t      col_out,
  output csum_t     sum
);

  col_t col_q;

  // The column moves one cell along the chain on every shift.
  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
  end

  assign col_out = col_q;

  // Weighted per-channel sum of the three rows held here.
  always_comb begin
    sum.red   = scale(col_q.top.red, wt.top) + scale(col_q.mid.red, wt.mid)
              + scale(col_q.bot.red, wt.bot);
    sum.green = scale(col_q.top.green, wt.top) + scale(col_q.mid.green, wt.mid)
              + scale(col_q.bot.green, wt.bot);
    sum.blue  = scale(col_q.top.blue, wt.top) + scale(col_q.mid.blue, wt.mid)
              + scale(col_q.bot.blue, wt.bot);
  end

endmodule
`default_nettype wire

FILE: hw/rtl/w3s_out_fifo.sv
// Small result queue that parts the arithmetic pipeline from the output stream.
// Depends on w3s_pkg and the assertion macros header.
`default_nettype none
`include "weighted_3x3_smooth_top_defines.svh"
module w3s_out_fifo
  import w3s_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire result_t          push_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output result_t               out_data,
  output logic      [CNT_W-1:0] count
);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             pop;

  assign out_valid = (cnt != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];
  assign count     = cnt;

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `SMOOTH_ASSERT(a_fifo_no_overflow, push |-> ((cnt < CNT_W'(DEPTH)) || pop), "result queue overflow")

endmodule
`default_nettype wire

FILE: hw/rtl/weighted_3x3_smooth_top.sv
// Top level of the center-weighted 3x3 smoothing block for square RGB images.
// Depends on w3s_pkg, w3s_ram, w3s_cell, w3s_out_fifo and the assertion macros header.
//
// Pixels of a size x size image enter in raster order on the slave stream with
// tuser low; after the last pixel, size+1 transfers with tuser high (a single one
// for a 1x1 image) bring out the rest of the frame, and m_tlast marks its final
// pixel. The block takes one item per clock for as long as results are taken;
// the limit is the eight-entry result queue, whose free room must cover the three
// pipeline stages behind the input. The transfer that causes a result passes the
// registered line buffer read, the window sums and the reciprocal multiply before
// the result enters the queue. For a size of two or more, output pixel k comes
// with input item k+size+1. The two line buffers are RAMs of MAX_SIZE words each
// and need no clearing pass after reset. Writing the size register restarts the
// frame; write it only while the block is idle.
`default_nettype none
`include "weighted_3x3_smooth_top_defines.svh"
module weighted_3x3_smooth_top
  import w3s_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_data,   // image_size
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [PX_W-1:0]   s_tdata,    // red_in, green_in, blue_in
  input  wire logic              s_tuser,    // op
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [PX_W-1:0]   m_tdata,    // red_out, green_out, blue_out
  output logic                   m_tlast     // frame_last
);

  localparam int COL_W      = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int SIZE_W     = $clog2(MAX_SIZE + 1);
  localparam int CLAMP_W    = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;
  localparam int RESET_SIZE = (SIZE_RESET > MAX_SIZE) ? MAX_SIZE : SIZE_RESET;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 4);
  localparam int PROD_W     = SUM_W + RECIP_W;

  // Frame geometry and position counters.
  logic [SIZE_W-1:0]  size;
  logic [COL_W-1:0]   last_idx;
  logic [CLAMP_W-1:0] cfg_ext;
  logic [SIZE_W-1:0]  cfg_size;
  logic [SIZE_W-1:0]  in_row, in_row_next;
  logic [COL_W-1:0]   in_col, in_col_next;
  logic [COL_W-1:0]   out_row, out_row_next;
  logic [COL_W-1:0]   out_col, out_col_next;

  logic  accept, is_flush, all_in, go, emit, col_wrap, out_last;
  edge_t edges;

  // Pipeline stages.
  logic             s1_v, s1_emit, s1_last;
  edge_t            s1_e;
  logic [COL_W-1:0] s1_col;
  pixel_t           s1_px;
  logic             s2_v, s2_last;
  edge_t            s2_e;
  logic             s3_v, s3_last;
  csum_t            s3_sum;
  logic [RECIP_W-1:0] s3_recip;

  // Line buffers and window.
  pixel_t lb1_rd, lb2_rd;
  col_t   new_col, col_right, col_center, col_left;
  wt_t    wt_right, wt_center, wt_left;
  csum_t  sum_right, sum_center, sum_left, win_sum;

  logic [PROD_W-1:0] prod_r, prod_g, prod_b;
  result_t           res, fifo_out;
  logic [CNT_W-1:0]  fifo_cnt;
  logic [OCC_W-1:0]  occ;

  assign last_idx = COL_W'(size - 1'b1);

  // Clamp a written size into 1..MAX_SIZE.
  always_comb begin
    cfg_ext = CLAMP_W'(cfg_data);
    if (cfg_ext == '0) begin
      cfg_size = SIZE_W'(1);
    end else if (cfg_ext > CLAMP_W'(MAX_SIZE)) begin
      cfg_size = SIZE_W'(MAX_SIZE);
    end else begin
      cfg_size = SIZE_W'(cfg_ext);
    end
  end

  // Input decode: pixels count until the frame is in, flushes only after that.
  assign accept   = s_tvalid && s_tready;
  assign is_flush = (s_tuser == OP_FLUSH);
  assign all_in   = (in_row == size);
  assign go       = accept && (is_flush ? all_in : !all_in);
  assign col_wrap = (in_col == last_idx);
  assign emit     = go && (is_flush || (in_row > SIZE_W'(1)) ||
                           ((in_row == SIZE_W'(1)) && (in_col != '0)));
  assign out_last = (out_row == last_idx) && (out_col == last_idx);

  // Border flags of the output pixel issued with this item.
  always_comb begin
    edges.top    = (out_row != '0);
    edges.bot    = (out_row != last_idx);
    edges.left   = (out_col != '0);
    edges.right  = (out_col != last_idx);
    edges.single = (size == SIZE_W'(1));
  end

  // Next values of the position counters.
  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    if (go) begin
      in_col_next = col_wrap ? '0 : in_col + 1'b1;
      if (!is_flush && col_wrap) begin
        in_row_next = in_row + 1'b1;
      end
    end
    if (emit) begin
      if (out_col == last_idx) begin
        out_col_next = '0;
        out_row_next = out_row + 1'b1;
      end else begin
        out_col_next = out_col + 1'b1;
      end
    end
    if ((emit && out_last) || cfg_we) begin
      in_row_next  = '0;
      in_col_next  = '0;
      out_row_next = '0;
      out_col_next = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      size    <= SIZE_W'(RESET_SIZE);
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      s3_v    <= 1'b0;
    end else begin
      if (cfg_we) begin
        size <= cfg_size;
      end
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
      s1_v    <= go;
      s2_v    <= s1_v && s1_emit;
      s3_v    <= s2_v;
    end
  end

  // Stage one: the pixel waits for the line buffer read of its column.
  always_ff @(posedge clk) begin
    s1_emit <= emit;
    s1_last <= out_last;
    s1_e    <= edges;
    s1_col  <= in_col;
    s1_px   <= pixel_t'(s_tdata);
  end

  // Line buffers: one row back and two rows back, addressed by column.
  w3s_ram #(.WIDTH(PX_W), .DEPTH(MAX_SIZE)) u_line1 (
    .clk   (clk),
    .we    (s1_v),
    .waddr (s1_col),
    .wdata (s1_px),
    .raddr (in_col),
    .rdata (lb1_rd)
  );

  w3s_ram #(.WIDTH(PX_W), .DEPTH(MAX_SIZE)) u_line2 (
    .clk   (clk),
    .we    (s1_v),
    .waddr (s1_col),
    .wdata (lb1_rd),
    .raddr (in_col),
    .rdata (lb2_rd)
  );

  assign new_col = '{top: lb2_rd, mid: lb1_rd, bot: s1_px};

  // Window weights: borders drop rows or columns, the center counts twice.
  always_comb begin
    wt_right.top  = (s2_e.right && s2_e.top) ? 2'd1 : 2'd0;
    wt_right.mid  = s2_e.right ? 2'd1 : 2'd0;
    wt_right.bot  = (s2_e.right && s2_e.bot) ? 2'd1 : 2'd0;
    wt_left.top   = (s2_e.left && s2_e.top) ? 2'd1 : 2'd0;
    wt_left.mid   = s2_e.left ? 2'd1 : 2'd0;
    wt_left.bot   = (s2_e.left && s2_e.bot) ? 2'd1 : 2'd0;
    wt_center.top = s2_e.top ? 2'd1 : 2'd0;
    // A 1x1 image has its only pixel one step further down the window.
    wt_center.mid = s2_e.single ? 2'd0 : 2'd2;
    wt_center.bot = s2_e.single ? 2'd2 : (s2_e.bot ? 2'd1 : 2'd0);
  end

  // Chain of three column cells: newest column on the right.
  w3s_cell u_cell_right (
    .clk     (clk),
    .shift   (s1_v),
    .col_in  (new_col),
    .wt      (wt_right),
    .col_out (col_right),
    .sum     (sum_right)
  );

  w3s_cell u_cell_center (
    .clk     (clk),
    .shift   (s1_v),
    .col_in  (col_right),
    .wt      (wt_center),
    .col_out (col_center),
    .sum     (sum_center)
  );

  w3s_cell u_cell_left (
    .clk     (clk),
    .shift   (s1_v),
    .col_in  (col_center),
    .wt      (wt_left),
    .col_out (col_left),
    .sum     (sum_left)
  );

  // Window sum over the three cells; the column shifted out of the left cell is dropped.
  always_comb begin
    win_sum.red   = sum_right.red + sum_center.red + sum_left.red;
    win_sum.green = sum_right.green + sum_center.green + sum_left.green;
    win_sum.blue  = sum_right.blue + sum_center.blue + sum_left.blue;
  end

  // Stage two to three: flags follow the column shift, sums get registered.
  always_ff @(posedge clk) begin
    s2_e     <= s1_e;
    s2_last  <= s1_last;
    s3_last  <= s2_last;
    s3_sum   <= win_sum;
    s3_recip <= recip(divisor(s2_e));
  end

  // Stage three: divide by the pixel count through a scaled reciprocal.
  assign prod_r = PROD_W'(s3_sum.red) * PROD_W'(s3_recip);
  assign prod_g = PROD_W'(s3_sum.green) * PROD_W'(s3_recip);
  assign prod_b = PROD_W'(s3_sum.blue) * PROD_W'(s3_recip);

  always_comb begin
    res.last     = s3_last;
    res.px.red   = prod_r[RECIP_SHIFT +: PIX_W];
    res.px.green = prod_g[RECIP_SHIFT +: PIX_W];
    res.px.blue  = prod_b[RECIP_SHIFT +: PIX_W];
  end

  w3s_out_fifo #(.DEPTH(FIFO_DEPTH)) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_v),
    .push_data (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (fifo_out),
    .count     (fifo_cnt)
  );

  assign m_tdata = fifo_out.px;
  assign m_tlast = fifo_out.last;

  // Take an item only when the queue has room for everything in flight.
  assign occ      = OCC_W'(fifo_cnt) + OCC_W'(s1_v) + OCC_W'(s2_v) + OCC_W'(s3_v);
  assign s_tready = (occ < OCC_W'(FIFO_DEPTH));

  `SMOOTH_ASSERT(a_occ_bound, occ <= OCC_W'(FIFO_DEPTH), "items in flight exceed queue room")
  `SMOOTH_ASSERT(a_in_col_range, in_col <= last_idx, "input column beyond image width")
  `SMOOTH_ASSERT(a_out_pos_range, (out_row <= last_idx) && (out_col <= last_idx), "output position outside image")
  `SMOOTH_ASSERT(a_restart, (emit && out_last) |=> ((in_row == '0) && (in_col == '0) && (out_row == '0) && (out_col == '0)), "frame did not restart after its last pixel")
  `SMOOTH_ASSERT_ALWAYS(a_reset_empty, rst |=> (occ == '0), "pipeline not empty after reset")

endmodule
`default_nettype wire

FILE: sim/weighted_3x3_smooth_top_tb.sv
// Self-checking testbench for the center-weighted 3x3 smoothing block.
// Needs w3s_pkg and weighted_3x3_smooth_top; compares every output transfer with its own
// model of the filter or a directed table value, under random idling on both streams.
`timescale 1ns / 100ps
module weighted_3x3_smooth_top_tb;
  import w3s_pkg::*;

  localparam int HIST_DEPTH = 2 * MAX_SIZE_DEF + 3;
  localparam int SETTLE     = 12;
  localparam int HOLD_LEN   = 300;
  localparam int RAND_ITEMS = 1150;

  typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_e;

  // One directed step: either a size write or an input transfer.
  typedef struct packed {
    row_kind_e        kind;
    logic [CFG_W-1:0] size;
    logic             op;
    pixel_t           px;
    logic             typed;
    result_t          want;
  } dir_row_t;

  // Pixels are written as 24'hBBGGRR, red in the lowest byte.
  localparam int DIR_N = 26;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // Reset size: an early flush and two pixels, none of them gives a result.
    '{ROW_ITEM, 11'd0, OP_FLUSH, 24'h000000, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_PIXEL, 24'hFFFFFF, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_PIXEL, 24'h000000, 1'b0, '{1'b0, 24'h000000}},
    // 1x1 image: the pixel comes back unchanged; extra pixel and early flush are ignored.
    '{ROW_SIZE, 11'd1, OP_PIXEL, 24'h000000, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_PIXEL, 24'h8000FF, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_PIXEL, 24'h123456, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_FLUSH, 24'h000000, 1'b1, '{1'b1, 24'h8000FF}},
    '{ROW_ITEM, 11'd0, OP_FLUSH, 24'h000000, 1'b0, '{1'b0, 24'h000000}},
    // Size zero acts as one.
    '{ROW_SIZE, 11'd0, OP_PIXEL, 24'h000000, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_PIXEL, 24'h01FF00, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_FLUSH, 24'h000000, 1'b1, '{1'b1, 24'h01FF00}},
    // 2x2 image of full-scale pixels, then a mixed one checked by the model.
    '{ROW_SIZE, 11'd2, OP_PIXEL, 24'h000000, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_PIXEL, 24'hFFFFFF, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_PIXEL, 24'hFFFFFF, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_PIXEL, 24'hFFFFFF, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_PIXEL, 24'hFFFFFF, 1'b1, '{1'b0, 24'hFFFFFF}},
    '{ROW_ITEM, 11'd0, OP_FLUSH, 24'h000000, 1'b1, '{1'b0, 24'hFFFFFF}},
    '{ROW_ITEM, 11'd0, OP_FLUSH, 24'h000000, 1'b1, '{1'b0, 24'hFFFFFF}},
    '{ROW_ITEM, 11'd0, OP_FLUSH, 24'h000000, 1'b1, '{1'b1, 24'hFFFFFF}},
    '{ROW_ITEM, 11'd0, OP_PIXEL, 24'h0000FF, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_PIXEL, 24'hFF0000, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_PIXEL, 24'h00FF00, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_PIXEL, 24'h000000, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_FLUSH, 24'h000000, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_FLUSH, 24'h000000, 1'b0, '{1'b0, 24'h000000}},
    '{ROW_ITEM, 11'd0, OP_FLUSH, 24'h000000, 1'b0, '{1'b0, 24'h000000}}
  };

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             cfg_we   = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [PX_W-1:0]  s_tdata  = '0;
  logic             s_tuser  = OP_PIXEL;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [PX_W-1:0]  m_tdata;
  logic             m_tlast;

  // Filter model state.
  logic [CFG_W-1:0] size_reg;
  pixel_t           hist [HIST_DEPTH];
  int               in_row;
  int               in_col;
  int               out_cnt;
  result_t          smooth_q [$];

  // Run control shared by the stimulus and the receiver.
  bit               calm = 1'b0;
  int               hold_asked = 0;
  int               fed = 0;
  int               errors = 0;

  weighted_3x3_smooth_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit idle_roll();
    return !calm && ($urandom_range(0, 99) < 19);
  endfunction

  // Size in use: zero counts as one, values above the maximum are clipped.
  function automatic int eff_size();
    if (size_reg == '0) return 1;
    if (int'(size_reg) > MAX_SIZE_DEF) return MAX_SIZE_DEF;
    return int'(size_reg);
  endfunction

  function automatic pixel_t rand_px();
    pixel_t p;
    int     mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return '0;
    if (mode == 1) return '1;
    p.red   = ($urandom_range(0, 5) == 0) ? {8{1'($urandom_range(0, 1))}} : 8'($urandom);
    p.green = ($urandom_range(0, 5) == 0) ? {8{1'($urandom_range(0, 1))}} : 8'($urandom);
    p.blue  = ($urandom_range(0, 5) == 0) ? {8{1'($urandom_range(0, 1))}} : 8'($urandom);
    return p;
  endfunction

  // Weighted average around output pixel k, clipped at the borders.
  function automatic result_t window_avg(input int k, input int sz);
    result_t res;
    pixel_t  p;
    int      r, c, r0, r1, c0, c1, w, n;
    int      sr, sg, sb;
    r  = k / sz;
    c  = k % sz;
    r0 = (r > 0) ? r - 1 : 0;
    r1 = (r + 1 < sz) ? r + 1 : r;
    c0 = (c > 0) ? c - 1 : 0;
    c1 = (c + 1 < sz) ? c + 1 : c;
    sr = 0;
    sg = 0;
    sb = 0;
    n  = 0;
    for (int rr = r0; rr <= r1; rr++) begin
      for (int cc = c0; cc <= c1; cc++) begin
        p  = hist[(rr * sz + cc) % HIST_DEPTH];
        w  = (rr == r && cc == c) ? 2 : 1;
        sr += w * int'(p.red);
        sg += w * int'(p.green);
        sb += w * int'(p.blue);
        n  += w;
      end
    end
    res.px.red   = 8'(sr / n);
    res.px.green = 8'(sg / n);
    res.px.blue  = 8'(sb / n);
    res.last     = (k + 1 == sz * sz);
    return res;
  endfunction

  task automatic restart_frame();
    in_row  = 0;
    in_col  = 0;
    out_cnt = 0;
  endtask

  // Advances the model by one accepted transfer.
  task automatic smooth_step(input logic op, input pixel_t px,
                             output bit used, output bit got, output result_t res);
    int sz, total, received;
    bit all_in;
    sz       = eff_size();
    total    = sz * sz;
    received = in_row * sz + in_col;
    all_in   = (in_row >= sz);
    used     = 1'b0;
    got      = 1'b0;
    res      = '0;
    if (op == OP_PIXEL) begin
      if (all_in) return;
      hist[received % HIST_DEPTH] = px;
      received++;
      in_col++;
      if (in_col >= sz) begin
        in_col = 0;
        in_row++;
      end
      used = 1'b1;
      if (received < sz + 2) return;
    end else begin
      if (!all_in || out_cnt >= total) return;
      used = 1'b1;
    end
    res = window_avg(out_cnt, sz);
    got = 1'b1;
    out_cnt++;
    if (out_cnt >= total) restart_frame();
  endtask

  // Offers one item until it is taken, then records what it should cause.
  task automatic drive_item(input logic op, input pixel_t px,
                            input bit typed, input result_t typed_res);
    bit      used;
    bit      got;
    result_t res;
    @(negedge clk);
    while (idle_roll()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    smooth_step(op, px, used, got, res);
    if (got) smooth_q.push_back(typed ? typed_res : res);
    if (used) fed++;
  endtask

  // Writes the size once all pending results are out and the pipeline is quiet.
  task automatic set_size(input logic [CFG_W-1:0] v);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (smooth_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    size_reg = v;
    restart_frame();
  endtask

  // Stimulus: directed table, random frames, then the largest size.
  initial begin
    int            ph;
    int            v;
    int            pick;
    int            sz;
    int            npx;
    bit            broken;
    dir_row_t      row;
    size_reg = 11'(SIZE_RESET);
    restart_frame();
    foreach (hist[i]) hist[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_TAB[i];
      if (row.kind == ROW_SIZE) set_size(row.size);
      else drive_item(row.op, row.px, row.typed, row.want);
    end

    ph = 0;
    while (fed < RAND_ITEMS) begin
      // Mostly small images, now and then a size of zero.
      if (ph == 0) begin
        v = 8;
      end else begin
        pick = $urandom_range(0, 19);
        v = (pick == 0) ? 0 : $urandom_range(1, (pick < 4) ? 16 : 7);
      end
      set_size(11'(v));
      calm = (ph == 2);
      sz = eff_size();
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        broken = (ph != 0) && ($urandom_range(0, 9) == 0);
        npx = broken ? $urandom_range(0, sz * sz - 1) : sz * sz;
        for (int i = 0; i < npx; i++) begin
          if ($urandom_range(0, 19) == 0) drive_item(OP_FLUSH, rand_px(), 1'b0, '0);
          drive_item(OP_PIXEL, rand_px(), 1'b0, '0);
          // Long receiver stall while pixels keep coming, to fill the block.
          if (ph == 0 && i == 4) hold_asked++;
        end
        if (broken) break;
        if ($urandom_range(0, 4) == 0) drive_item(OP_PIXEL, rand_px(), 1'b0, '0);
        for (int i = 0; i < ((sz * sz < sz + 1) ? sz * sz : sz + 1); i++) begin
          drive_item(OP_FLUSH, rand_px(), 1'b0, '0);
        end
        if ($urandom_range(0, 4) == 0) drive_item(OP_FLUSH, rand_px(), 1'b0, '0);
      end
      calm = 1'b0;
      ph++;
    end

    // Largest size: a short partial frame, then clipping from above with
    // enough pixels past one full-width row for the first outputs.
    set_size(11'(MAX_SIZE_DEF));
    for (int i = 0; i < 30; i++) drive_item(OP_PIXEL, rand_px(), 1'b0, '0);
    set_size('1);
    for (int i = 0; i < MAX_SIZE_DEF + 6; i++) drive_item(OP_PIXEL, rand_px(), 1'b0, '0);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (smooth_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0 && smooth_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Receiver: random idling, plus one long hold-off when asked for.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_seen) begin
        hold_seen = hold_asked;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !idle_roll();
      end
    end
  end

  // Compare each output transfer with the oldest predicted pixel.
  always @(posedge clk) begin
    result_t want;
    pixel_t  seen;
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata;
      if (smooth_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected output r=%0d g=%0d b=%0d last=%0d",
                   seen.red, seen.green, seen.blue, m_tlast);
        end
      end else begin
        want = smooth_q.pop_front();
        if (seen.red !== want.px.red || seen.green !== want.px.green ||
            seen.blue !== want.px.blue || m_tlast !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
                     want.px.red, want.px.green, want.px.blue, want.last,
                     seen.red, seen.green, seen.blue, m_tlast);
          end
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
